/* sv/assert_macros.svh */
// assertion helpers shared by the parser modules
// expects aclk and aresetn in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tlvp_pkg.sv */
// types and constants shared by the tlv record parser modules
// no dependencies
`default_nettype none

package tlvp_pkg;

    localparam logic [31:0] HEAD_BYTES  = 32'd6;
    localparam logic [31:0] WORD32_LEN  = 32'd4;
    localparam logic [31:0] WORD64_LEN  = 32'd8;

    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_TRUNC   = 2'd2,
        KIND_OVERRUN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        WORD_NONE = 2'd0,
        WORD_U32  = 2'd1,
        WORD_S64  = 2'd2
    } word_kind_t;

    // one classified result on its way from the front to the back
    typedef struct packed {
        kind_t       kind;
        logic [15:0] tag;
        logic [31:0] len;
        logic [7:0]  data;
        logic        last;
        logic        acc_en;
        logic [2:0]  acc_idx;
        word_kind_t  word_kind;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/tlvp_front.sv */
// front end: holds the message length register and the header/value parse state,
// classifies each input beat into a result command; uses tlvp_pkg
`default_nettype none

`include "assert_macros.svh"

module tlvp_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [31:0]   cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    input  wire logic          q_full,
    output logic               push,
    output tlvp_pkg::cmd_t     cmd
);
    import tlvp_pkg::*;

    logic [31:0] msg_reg;
    logic [31:0] pos_reg,  pos_next;
    logic [2:0]  hc_reg,   hc_next;
    logic [15:0] tag_reg,  tag_next;
    logic [31:0] len_reg,  len_next;
    logic [31:0] vrem_reg, vrem_next;
    logic        err_reg,  err_next;

    logic        take;
    logic        restart;
    logic [31:0] remaining;
    logic        is_word;
    logic        last;

    assign s_ready   = !q_full;
    assign take      = s_valid && !q_full;
    assign remaining = msg_reg - pos_reg;
    assign is_word   = (len_reg == WORD32_LEN) || (len_reg == WORD64_LEN);
    assign last      = (vrem_reg == 32'd1);

    always_comb begin
        pos_next  = pos_reg;
        hc_next   = hc_reg;
        tag_next  = tag_reg;
        len_next  = len_reg;
        vrem_next = vrem_reg;
        err_next  = err_reg;
        restart   = 1'b0;
        push      = 1'b0;
        cmd       = '0;

        if (take && msg_reg != 32'd0) begin
            if (pos_reg >= msg_reg) begin
                // length lowered under the current position
                restart = 1'b1;
            end else begin
                if (err_reg) begin
                    // drop until message end
                end else if (vrem_reg != 32'd0) begin
                    push          = 1'b1;
                    cmd.kind      = KIND_VALUE;
                    cmd.tag       = tag_reg;
                    cmd.len       = len_reg;
                    cmd.data      = s_data_byte;
                    cmd.last      = last;
                    cmd.acc_en    = is_word;
                    cmd.acc_idx   = len_reg[2:0] - vrem_reg[2:0];
                    if (is_word && last) begin
                        cmd.word_kind = (len_reg == WORD32_LEN) ? WORD_U32 : WORD_S64;
                    end else begin
                        cmd.word_kind = WORD_NONE;
                    end
                    vrem_next = vrem_reg - 32'd1;
                end else if (hc_reg == 3'd0 && remaining < HEAD_BYTES) begin
                    push     = 1'b1;
                    cmd.kind = KIND_TRUNC;
                    err_next = 1'b1;
                end else begin
                    case (hc_reg)
                        3'd0: tag_next = {8'h00, s_data_byte};
                        3'd1: tag_next = {s_data_byte, tag_reg[7:0]};
                        3'd2: len_next = {24'h000000, s_data_byte};
                        3'd3: len_next = {len_reg[31:16], s_data_byte, len_reg[7:0]};
                        3'd4: len_next = {len_reg[31:24], s_data_byte, len_reg[15:0]};
                        3'd5: len_next = {s_data_byte, len_reg[23:0]};
                        default: ;
                    endcase
                    if (hc_reg >= 3'd5) begin
                        hc_next = 3'd0;
                        // length must fit in the bytes after this one
                        if (len_next >= remaining) begin
                            push     = 1'b1;
                            cmd.kind = KIND_OVERRUN;
                            cmd.tag  = tag_reg;
                            cmd.len  = len_next;
                            err_next = 1'b1;
                        end else if (len_next == 32'd0) begin
                            push     = 1'b1;
                            cmd.kind = KIND_EMPTY;
                            cmd.tag  = tag_reg;
                        end else begin
                            vrem_next = len_next;
                        end
                    end else begin
                        hc_next = hc_reg + 3'd1;
                    end
                end
                pos_next = pos_reg + 32'd1;
                if (pos_next == msg_reg) begin
                    restart = 1'b1;
                end
            end
        end

        if (restart) begin
            pos_next  = '0;
            hc_next   = '0;
            tag_next  = '0;
            len_next  = '0;
            vrem_next = '0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_reg  <= '0;
            pos_reg  <= '0;
            hc_reg   <= '0;
            tag_reg  <= '0;
            len_reg  <= '0;
            vrem_reg <= '0;
            err_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                msg_reg <= cfg_wr_data;
            end
            pos_reg  <= pos_next;
            hc_reg   <= hc_next;
            tag_reg  <= tag_next;
            len_reg  <= len_next;
            vrem_reg <= vrem_next;
            err_reg  <= err_next;
        end
    end

    `ASSERT_IMPLIES(a_value_in_value_phase, push && cmd.kind == KIND_VALUE,
        vrem_reg != 32'd0 && !err_reg, "value beat outside value phase")
    `ASSERT_ALWAYS(a_header_count_range, hc_reg <= 3'd5, "header count out of range")
    `ASSERT_IMPLIES(a_no_header_in_value, vrem_reg != 32'd0, hc_reg == 3'd0,
        "header count moved during value phase")

endmodule

`default_nettype wire

/* sv/tlvp_queue.sv */
// short command queue between the parse front end and the output back end
// uses tlvp_pkg for the command type
`default_nettype none

`include "assert_macros.svh"

module tlvp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  tlvp_pkg::cmd_t      push_cmd,
    input  wire logic           pop,
    output tlvp_pkg::cmd_t      head_cmd,
    output logic                full,
    output logic                empty
);
    import tlvp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMPLIES(a_no_push_when_full, push, !full, "push into full queue")
    `ASSERT_IMPLIES(a_no_pop_when_empty, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

/* sv/tlvp_back.sv */
// back end: assembles 4/8-byte value words and drives the result output register
// uses tlvp_pkg for the command type and codes
`default_nettype none

`include "assert_macros.svh"

module tlvp_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  tlvp_pkg::cmd_t     head_cmd,
    input  wire logic          q_empty,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_result_kind,
    output logic [15:0]        m_record_tag,
    output logic [31:0]        m_record_length,
    output logic [7:0]         m_value_byte,
    output logic               m_last_value_byte,
    output logic [1:0]         m_word_kind,
    output logic [63:0]        m_word_value
);
    import tlvp_pkg::*;

    logic        m_valid_reg;
    logic [63:0] acc_reg;
    logic [63:0] acc_base;
    logic [63:0] acc_merged;

    assign pop     = !q_empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    // first value byte starts a fresh word
    assign acc_base   = (head_cmd.acc_idx == 3'd0) ? 64'd0 : acc_reg;
    assign acc_merged = acc_base | ({56'd0, head_cmd.data} << {head_cmd.acc_idx, 3'b000});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (head_cmd.acc_en) begin
                acc_reg <= acc_merged;
            end
            m_result_kind     <= head_cmd.kind;
            m_record_tag      <= head_cmd.tag;
            m_record_length   <= head_cmd.len;
            m_value_byte      <= head_cmd.data;
            m_last_value_byte <= head_cmd.last;
            m_word_kind       <= head_cmd.word_kind;
            m_word_value      <= (head_cmd.word_kind != WORD_NONE) ? acc_merged : 64'd0;
        end
    end

    `ASSERT_NEXT(a_pop_loads_output, pop, m_valid_reg, "popped beat not presented")
    `ASSERT_IMPLIES(a_word_on_last, m_valid_reg && m_word_kind != WORD_NONE,
        m_last_value_byte && m_result_kind == KIND_VALUE, "word outside last value beat")

endmodule

`default_nettype wire

/* sv/tlv_record_stream_parser_unit.sv */
// TLV record stream parser. Takes one message byte per cycle on s_* and gives at most
// one result per byte on m_*: value beats with tag and length, an empty-record beat,
// or a truncated-header / length-overrun error, after which the rest of the message
// is dropped. Records are a 16-bit LE tag, a 32-bit LE length, then the value; the
// last beat of a 4- or 8-byte value also carries the assembled LE word. Sustained
// rate is one byte per cycle while m_ready holds: the front end's per-byte parse
// update (position count and the 32-bit length-against-remaining compare) sets it,
// and a QUEUE_DEPTH queue plus the output register let input and output stall on
// their own. Write cfg_wr_data (message length) only while idle; a message length
// of zero makes the block swallow bytes silently.
`default_nettype none

module tlv_record_stream_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [31:0]   cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_data_byte,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [1:0]         m_result_kind,
    output logic [15:0]        m_record_tag,
    output logic [31:0]        m_record_length,
    output logic [7:0]         m_value_byte,
    output logic               m_last_value_byte,
    output logic [1:0]         m_word_kind,
    output logic [63:0]        m_word_value
);
    import tlvp_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    tlvp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    tlvp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    tlvp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_cmd          (head_cmd),
        .q_empty           (q_empty),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_record_tag      (m_record_tag),
        .m_record_length   (m_record_length),
        .m_value_byte      (m_value_byte),
        .m_last_value_byte (m_last_value_byte),
        .m_word_kind       (m_word_kind),
        .m_word_value      (m_word_value)
    );

endmodule

`default_nettype wire
